### rtl/bsha1_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsha1_pkg: shared types and constants of the broken SHA-1 hash core
// Holds the controller states, the command bundle from the controller to the
// datapath, and the fixed hash constants.
// ----------------------------------------------------------------------------
package bsha1_pkg;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned MSG_WORDS   = 16;
   localparam int unsigned DIGEST_WORDS = 5;

   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hefcdab89;
   localparam logic [31:0] H2 = 32'h98badcfe;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hc3d2e1f0;

   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   // The third and fourth constants are the negations of 0x70e44324 and
   // 0x359d3e2a.
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   localparam logic [6:0] PHASE1_START = 7'd20;
   localparam logic [6:0] PHASE2_START = 7'd40;
   localparam logic [6:0] PHASE3_START = 7'd60;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic       load_byte;  // store the accepted byte
      logic       init_regs;  // load the initial values into the working registers
      logic       do_round;   // run one round and advance the schedule
      logic [6:0] round_idx;  // number of the round being run
      logic       finish;     // add initial values, clear the message store
      logic [2:0] out_idx;    // digest word on the result channel
   } cmd_type;

endpackage
`default_nettype wire

### rtl/bsha1_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsha1_req_if / bsha1_rsp_if: handshake channels of the broken SHA-1 core
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface bsha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface
`default_nettype wire

### rtl/bsha1_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsha1_ctrl: sequencing of the broken SHA-1 core
// Accepts bytes while idle, steps through the eighty rounds, folds in the
// initial values and hands out the five digest words.
// ----------------------------------------------------------------------------
module bsha1_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_last,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output bsha1_pkg::cmd_type cmd
);

   bsha1_pkg::state_type state_ff, state_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] out_ff, out_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsha1_pkg::ST_IDLE: begin
            if (req_valid && req_last) begin
               state_in = bsha1_pkg::ST_ROUND;
            end
         end
         bsha1_pkg::ST_ROUND: begin
            if (round_ff == bsha1_pkg::LAST_ROUND) begin
               state_in = bsha1_pkg::ST_FINISH;
            end
         end
         bsha1_pkg::ST_FINISH: begin
            state_in = bsha1_pkg::ST_OUTPUT;
         end
         bsha1_pkg::ST_OUTPUT: begin
            if (rsp_ready && out_ff == bsha1_pkg::LAST_WORD_INDEX) begin
               state_in = bsha1_pkg::ST_IDLE;
            end
         end
         default: state_in = bsha1_pkg::ST_IDLE;
      endcase
   end

   // Outputs and counters
   always_comb begin
      req_ready = (state_ff == bsha1_pkg::ST_IDLE);
      rsp_valid = (state_ff == bsha1_pkg::ST_OUTPUT);
      round_in  = round_ff;
      out_in    = out_ff;
      if (state_ff == bsha1_pkg::ST_ROUND) begin
         round_in = (round_ff == bsha1_pkg::LAST_ROUND) ? 7'd0 : round_ff + 7'd1;
      end
      if (rsp_take) begin
         out_in = (out_ff == bsha1_pkg::LAST_WORD_INDEX) ? 3'd0 : out_ff + 3'd1;
      end
      cmd.load_byte = req_take;
      cmd.init_regs = req_take && req_last;
      cmd.do_round  = (state_ff == bsha1_pkg::ST_ROUND);
      cmd.round_idx = round_ff;
      cmd.finish    = (state_ff == bsha1_pkg::ST_FINISH);
      cmd.out_idx   = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsha1_pkg::ST_IDLE;
         round_ff <= 7'd0;
         out_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         out_ff   <= out_in;
      end
   end

endmodule
`default_nettype wire

### rtl/bsha1_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsha1_datapath: message store, schedule window and round logic
// The sixteen message words double as the sliding schedule window during
// the rounds; one round is computed per cycle.
// ----------------------------------------------------------------------------
module bsha1_datapath (
   input  wire                clock,
   input  wire                reset,
   input  bsha1_pkg::cmd_type cmd,
   input  wire  [7:0]         data_byte,
   output logic [31:0]        digest_word,
   output logic [2:0]         word_index,
   output logic               last_word
);

   logic [31:0] msg_ff [bsha1_pkg::MSG_WORDS];
   logic [6:0]  count_ff;
   logic [31:0] work_ff [bsha1_pkg::DIGEST_WORDS];

   logic [31:0] a, b, c, d, e;
   logic [31:0] f, k, t;
   logic [31:0] sched_xor;
   logic [31:0] sched_new;

   assign a = work_ff[0];
   assign b = work_ff[1];
   assign c = work_ff[2];
   assign d = work_ff[3];
   assign e = work_ff[4];

   // The window holds w[i] .. w[i+15]; the broken schedule yields a single set bit.
   assign sched_xor = msg_ff[0] ^ msg_ff[2] ^ msg_ff[8] ^ msg_ff[13];
   assign sched_new = 32'd1 << sched_xor[4:0];

   always_comb begin
      priority if (cmd.round_idx < bsha1_pkg::PHASE1_START) begin
         f = (b & c) | (~b & d);
         k = bsha1_pkg::K0;
      end else if (cmd.round_idx < bsha1_pkg::PHASE2_START) begin
         f = b ^ c ^ d;
         k = bsha1_pkg::K1;
      end else if (cmd.round_idx < bsha1_pkg::PHASE3_START) begin
         f = (b & c) | (b & d) | (c & d);
         k = bsha1_pkg::K2;
      end else begin
         f = b ^ c ^ d;
         k = bsha1_pkg::K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + msg_ff[0];
   end

   // Message store and byte count
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         for (int j = 0; j < bsha1_pkg::MSG_WORDS; j++) begin
            msg_ff[j] <= 32'd0;
         end
         count_ff <= 7'd0;
      end else if (cmd.do_round) begin
         for (int j = 0; j < bsha1_pkg::MSG_WORDS - 1; j++) begin
            msg_ff[j] <= msg_ff[j + 1];
         end
         msg_ff[bsha1_pkg::MSG_WORDS - 1] <= sched_new;
      end else if (cmd.load_byte && !count_ff[6]) begin
         // Bytes past the end of the block are dropped; the count saturates.
         msg_ff[count_ff[5:2]][{count_ff[1:0], 3'b000} +: 8] <= data_byte;
         count_ff <= count_ff + 7'd1;
      end
   end

   // Working registers, which end up holding the digest
   always_ff @(posedge clock) begin
      if (cmd.init_regs) begin
         work_ff[0] <= bsha1_pkg::H0;
         work_ff[1] <= bsha1_pkg::H1;
         work_ff[2] <= bsha1_pkg::H2;
         work_ff[3] <= bsha1_pkg::H3;
         work_ff[4] <= bsha1_pkg::H4;
      end else if (cmd.do_round) begin
         work_ff[0] <= t;
         work_ff[1] <= a;
         work_ff[2] <= {b[1:0], b[31:2]};
         work_ff[3] <= c;
         work_ff[4] <= d;
      end else if (cmd.finish) begin
         // Each digest word is the initial value plus the final working register.
         work_ff[0] <= a + bsha1_pkg::H0;
         work_ff[1] <= b + bsha1_pkg::H1;
         work_ff[2] <= c + bsha1_pkg::H2;
         work_ff[3] <= d + bsha1_pkg::H3;
         work_ff[4] <= e + bsha1_pkg::H4;
      end
   end

   always_comb begin
      unique case (cmd.out_idx)
         3'd0:    digest_word = work_ff[0];
         3'd1:    digest_word = work_ff[1];
         3'd2:    digest_word = work_ff[2];
         3'd3:    digest_word = work_ff[3];
         default: digest_word = work_ff[4];
      endcase
      word_index = cmd.out_idx;
      last_word  = (cmd.out_idx == bsha1_pkg::LAST_WORD_INDEX);
   end

endmodule
`default_nettype wire

### rtl/broken_sha1_single_block_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// broken_sha1_single_block_core: single-block hash with the broken schedule
// Message bytes come in on req_if, one item per byte, little-endian into a
// 64-byte block; last_byte closes the message and starts the hash. Bytes
// past the sixty-fourth are dropped, unwritten bytes are zero and no length
// padding is added. The digest leaves on rsp_if as five items, word_index
// 0 to 4, with last_word set on the fifth.
// While idle the core takes message bytes back to back. After the last
// byte the core runs 80 rounds, one per cycle on a single round unit, then
// a finish step adds the initial values, and the digest words follow one
// per cycle while rsp_if is ready. req_if.ready is high only while the
// core is idle.
// If the receiver stalls, the current digest word is held and no new byte is
// taken until the fifth word is delivered.
// A synchronous reset clears the message store, the byte count and the
// controller; the core is ready as soon as reset falls.
// ----------------------------------------------------------------------------
module broken_sha1_single_block_core (
   input wire          clock,
   input wire          reset,
   bsha1_req_if.sink   req_if,
   bsha1_rsp_if.source rsp_if
);

   bsha1_pkg::cmd_type cmd;

   bsha1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_byte),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   bsha1_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_if.data_byte),
      .digest_word (rsp_if.digest_word),
      .word_index  (rsp_if.word_index),
      .last_word   (rsp_if.last_word)
   );

endmodule
`default_nettype wire

### rtl/bsha1_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsha1_checker: port-level checks of the broken SHA-1 core
// Watches both channels and checks the ordering of the digest words.
// ----------------------------------------------------------------------------
module bsha1_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        req_last_byte,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_digest_word,
   input wire [2:0]  rsp_word_index,
   input wire        rsp_last_word
);

   // A stalled digest word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
         && $stable(rsp_word_index))
      else $error("digest word changed while stalled");

   // The item that closes a message makes the core busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> !req_ready && !rsp_valid)
      else $error("core not busy after the last byte");

   // No byte is taken while digest words are pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("byte taken while the digest is pending");

   // Digest words come in order.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest words out of order");

   // The fifth word ends the digest.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_word |=> !rsp_valid)
      else $error("result after the last digest word");

endmodule

bind broken_sha1_single_block_core bsha1_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_last_byte   (req_if.last_byte),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_digest_word (rsp_if.digest_word),
   .rsp_word_index  (rsp_if.word_index),
   .rsp_last_word   (rsp_if.last_word)
);
`default_nettype wire
